### design/aphq_pkg.sv
// shared types, constants and arithmetic helpers of the allpass hilbert quadrature block
`timescale 1ns / 1ps
`default_nettype none

package aphq_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int SECTIONS      = 4;
    localparam int SEC_BITS      = 2;
    localparam int COEF_BITS     = 16;
    localparam int COEF_FRAC     = 15;
    localparam int STATE_BITS    = 32;
    localparam int PROD_BITS     = COEF_BITS + STATE_BITS;
    localparam int ALIGN_SHIFT   = 30 - SAMPLE_BITS;
    localparam int NUM_REGS      = 2 * SECTIONS;
    localparam int REG_SEL_BITS  = SEC_BITS + 1;
    localparam int REG_IDX_BITS  = 4;
    localparam int RAM_DEPTH     = 2 * SECTIONS;
    localparam int RAM_ADDR_BITS = SEC_BITS + 1;
    localparam int CNT_BITS      = 5;
    localparam int LAST_CNT      = 4 * SECTIONS;

    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [STATE_BITS-1:0]  acc_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } aphq_state_t;

    // in-phase sections 0..3, then quadrature sections 0..3
    localparam coef_t COEF_RESET [NUM_REGS] = '{
        -16'sd32752, -16'sd32304, -16'sd28368, -16'sd11664,
        -16'sd32688, -16'sd31360, -16'sd21472, -16'sd1760
    };

    localparam logic signed [STATE_BITS+1:0] ACC_MAX = 34'sd2147483647;
    localparam logic signed [STATE_BITS+1:0] ACC_MIN = -34'sd2147483648;
    localparam logic signed [STATE_BITS-ALIGN_SHIFT-1:0] OUT_MAX = 26'sd8388607;
    localparam logic signed [STATE_BITS-ALIGN_SHIFT-1:0] OUT_MIN = -26'sd8388608;

    // saturate a grown sum back to the 32-bit state range
    function automatic acc_t sat_acc(input logic signed [STATE_BITS+1:0] v);
        acc_t r;
        if (v > ACC_MAX)
            r = acc_t'(ACC_MAX);
        else if (v < ACC_MIN)
            r = acc_t'(ACC_MIN);
        else
            r = v[STATE_BITS-1:0];
        return r;
    endfunction

    // floor shift from Q3.29 down to the sample format, then saturate
    function automatic sample_t sat_out(input acc_t y);
        logic signed [STATE_BITS-ALIGN_SHIFT-1:0] v;
        sample_t r;
        v = y[STATE_BITS-1:ALIGN_SHIFT];
        if (v > OUT_MAX)
            r = sample_t'(OUT_MAX);
        else if (v < OUT_MIN)
            r = sample_t'(OUT_MIN);
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### design/allpass_hilbert_quadrature.sv
// allpass iir hilbert transformer: two four-section allpass branches giving an i/q pair
// a request is accepted in ST_IDLE and run on the single shared 16x32 multiplier, which does
//   two products per section for both branches (16 multiplies a request); the result is then
//   loaded, via ST_HOLD while the output is stalled, and in_stall holds off new requests until then
// reset: coefficients return to their default values, all section states read as zero,
//   no result is pending
`timescale 1ns / 1ps
`default_nettype none

module allpass_hilbert_quadrature
    import aphq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // sample request channel
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [SAMPLE_BITS-1:0]  sample_in,
    // result channel
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [SAMPLE_BITS-1:0]       i_out,
    output logic [SAMPLE_BITS-1:0]       q_out,
    // coefficient write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [REG_IDX_BITS-1:0] cfg_index,
    input  wire logic [COEF_BITS-1:0]    cfg_data
);

    // schedule inside one request, cnt = 4k + phase for section k:
    //   phase 0: multiply a_i[k] * x_i, read in-phase state k,
    //            write back quadrature state k-1 (k > 0)
    //   phase 1: multiply a_q[k] * x_q, read quadrature state k, y_i = a*x + s
    //   phase 2: multiply a_i[k] * y_i, y_q = a*x + s
    //   phase 3: multiply a_q[k] * y_q, write back in-phase state k = x - a*y
    //   cnt 16:  write back the last quadrature state and load the result
    // each state entry is read once and written back later in the same request, and the
    // next read of it belongs to the next request, so no forwarding is needed

    aphq_state_t state_reg, state_next;

    logic [CNT_BITS-1:0] cnt_reg;
    logic [1:0]          phase;
    logic [SEC_BITS-1:0] sec;
    logic                last_step;

    logic start;
    logic step;
    logic out_load;

    coef_t coef_reg [NUM_REGS];

    acc_t x_i_reg, x_q_reg;
    acc_t y_i_reg, y_q_reg;
    acc_t x_aligned;

    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] prod_next;
    logic signed [STATE_BITS:0]  prod_sh;
    coef_t                       mul_coef;
    acc_t                        mul_op;

    // state memory and its valid bits
    logic                     st_we;
    logic [RAM_ADDR_BITS-1:0] st_waddr;
    acc_t                     st_wdata;
    logic [RAM_ADDR_BITS-1:0] st_raddr;
    logic [STATE_BITS-1:0]    st_rdata;
    logic [RAM_DEPTH-1:0]     st_vld_reg;
    logic                     rd_vld_reg;
    acc_t                     st_rd;

    logic signed [STATE_BITS+1:0] y_sum;
    logic signed [STATE_BITS+1:0] s_diff;
    acc_t                         x_sel;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] i_out_reg, q_out_reg;
    logic                   out_free;

    assign phase     = cnt_reg[1:0];
    assign sec       = cnt_reg[SEC_BITS+1:2];
    assign last_step = (cnt_reg == CNT_BITS'(LAST_CNT));
    assign out_free  = !out_valid_reg || !out_stall;

    // control state machine
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        start      = 1'b0;
        step       = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    start      = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                step = 1'b1;
                if (last_step)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                // result waits for the output register to free up
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= '0;
        end
        else if (step && !last_step)
        begin
            cnt_reg <= cnt_reg + CNT_BITS'(1);
        end
    end

    // coefficient registers, writes beyond the last register are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                coef_reg[r] <= COEF_RESET[r];
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < REG_IDX_BITS'(NUM_REGS)))
        begin
            coef_reg[cfg_index[REG_SEL_BITS-1:0]] <= cfg_data;
        end
    end

    // sample aligned from Q1.23 to Q3.29
    assign x_aligned = {{(STATE_BITS - SAMPLE_BITS - ALIGN_SHIFT){sample_in[SAMPLE_BITS-1]}},
                        sample_in, {ALIGN_SHIFT{1'b0}}};

    // shared multiplier: branch from phase bit 0, section from the counter
    assign mul_coef = coef_reg[{phase[0], sec}];

    always_comb
    begin
        case (phase)
            2'd0:    mul_op = x_i_reg;
            2'd1:    mul_op = x_q_reg;
            2'd2:    mul_op = y_i_reg;
            2'd3:    mul_op = y_q_reg;
            default: mul_op = x_i_reg;
        endcase
    end

    assign prod_next = mul_coef * mul_op;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // product truncated toward minus infinity back to Q3.29 (33 bits before saturation)
    assign prod_sh = prod_reg[PROD_BITS-1:COEF_FRAC];

    // state memory access
    assign st_raddr = {phase[0], sec};
    assign st_rd    = rd_vld_reg ? acc_t'(st_rdata) : '0;

    assign x_sel  = (phase == 2'd3) ? x_i_reg : x_q_reg;
    assign y_sum  = (STATE_BITS+2)'(prod_sh) + (STATE_BITS+2)'(st_rd);
    assign s_diff = (STATE_BITS+2)'(x_sel) - (STATE_BITS+2)'(prod_sh);

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = {1'b0, sec};
        st_wdata = sat_acc(s_diff);
        if (step)
        begin
            if (phase == 2'd3)
            begin
                st_we    = 1'b1;
                st_waddr = {1'b0, sec};
            end
            else if ((phase == 2'd0) && (cnt_reg != '0))
            begin
                // quadrature state of the section just finished
                st_we    = 1'b1;
                st_waddr = {1'b1, sec - SEC_BITS'(1)};
            end
        end
    end

    aphq_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (st_we)
            begin
                st_vld_reg[st_waddr] <= 1'b1;
            end
            rd_vld_reg <= st_vld_reg[st_raddr];
        end
    end

    // branch signal registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_i_reg <= x_aligned;
            x_q_reg <= x_aligned;
        end
        else if (step)
        begin
            case (phase)
                2'd0:
                begin
                    if (cnt_reg != '0)
                    begin
                        x_q_reg <= y_q_reg;
                    end
                end
                2'd1:
                begin
                    y_i_reg <= sat_acc(y_sum);
                end
                2'd2:
                begin
                    y_q_reg <= sat_acc(y_sum);
                end
                2'd3:
                begin
                    x_i_reg <= y_i_reg;
                end
                default:
                begin
                    x_i_reg <= x_i_reg;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            i_out_reg <= sat_out(y_i_reg);
            q_out_reg <= sat_out(y_q_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign i_out     = i_out_reg;
    assign q_out     = q_out_reg;

endmodule

`default_nettype wire

### design/aphq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module aphq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
